@@ hdl/sbbd_pkg.sv @@
package sbbd_pkg;

    // result status codes
    localparam logic [1:0] ST_DATA     = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_STOP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_BYTE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_STOP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_FRNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_BACK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 3'd5;

    // input item: received byte or timeout event
    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } t_out_item;

endpackage

@@ hdl/stop_byte_barcode_deframer.sv @@
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+-----------------------
// input    | in        | i_in_valid / o_in_ready   | i_in  (mode, rx_byte)
// result   | out       | o_out_valid / i_out_ready | o_out (out_byte, status, last)
// config   | in        | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
// A byte that only extends the frame, or one that gives a status result, is handled in idle.
// A completed frame streams out of the frame memory byte by byte (a read state, then a
// show state into the output register); input is held off until the last byte leaves.
// Reset (synchronous, active low) clears control state and loads the register defaults.
// The frame memory has no clearing pass: only written entries are read back.
// A stalled output register holds its result and blocks further input.
module stop_byte_barcode_deframer #(
    parameter int unsigned FRAME_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  sbbd_pkg::t_in_item            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output sbbd_pkg::t_out_item           o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [sbbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);
    import sbbd_pkg::*;

    localparam int unsigned AW = $clog2(FRAME_DEPTH);
    localparam int unsigned LW = $clog2(FRAME_DEPTH + 1);
    localparam int unsigned CW = (LW > 7) ? LW : 7;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SHOW = 3'b100
    } t_state;

    // configuration registers
    logic       r_use_stop;
    logic [7:0] r_stop_byte;
    logic       r_drop_stop;
    logic [5:0] r_trim_front;
    logic [5:0] r_trim_back;
    logic [5:0] r_max_len;

    t_state          r_state, n_state;
    logic [LW-1:0]   r_len, n_len;
    logic [AW-1:0]   r_rd_addr, n_rd_addr;
    logic [AW-1:0]   r_last_addr, n_last_addr;
    logic [7:0]      r_rd_data;
    t_out_item       r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic [7:0] mem [FRAME_DEPTH];

    logic          in_xfer;
    logic          out_free;
    logic          store_full;
    logic [LW-1:0] len_inc;
    logic [CW-1:0] cut;
    logic [CW-1:0] emit_len;
    logic [CW-1:0] last_full;
    logic          do_emit;
    logic          do_status;
    logic [1:0]    status_code;
    logic          mem_we;
    logic          show_last;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign store_full = (r_len == LW'(FRAME_DEPTH));
    assign len_inc    = r_len + LW'(1);
    assign cut        = CW'(r_trim_front) + CW'(r_trim_back);
    assign last_full  = emit_len - CW'(r_trim_back) - CW'(1);
    assign show_last  = (r_rd_addr == r_last_addr);

    // decode one accepted item
    always_comb begin
        do_emit     = 1'b0;
        do_status   = 1'b0;
        status_code = ST_EMPTY;
        mem_we      = 1'b0;
        emit_len    = CW'(r_len);
        n_len       = r_len;
        if (in_xfer) begin
            if (i_in.mode) begin
                if (r_use_stop) begin
                    do_status   = 1'b1;
                    status_code = ST_TIMEOUT;
                end else begin
                    do_emit = 1'b1;
                end
            end else if (r_use_stop && (i_in.rx_byte == r_stop_byte)) begin
                if (!r_drop_stop) begin
                    if (store_full) begin
                        do_status   = 1'b1;
                        status_code = ST_OVERFLOW;
                    end else begin
                        mem_we   = 1'b1;
                        emit_len = CW'(len_inc);
                        do_emit  = 1'b1;
                    end
                end else begin
                    do_emit = 1'b1;
                end
            end else begin
                if (store_full) begin
                    do_status   = 1'b1;
                    status_code = ST_OVERFLOW;
                end else begin
                    mem_we = 1'b1;
                    if (CW'(len_inc) > CW'(r_max_len)) begin
                        do_status   = 1'b1;
                        status_code = ST_OVERFLOW;
                    end else begin
                        n_len = len_inc;
                    end
                end
            end
            // trimming that leaves nothing gives the empty status
            if (do_emit && (emit_len <= cut)) begin
                do_emit     = 1'b0;
                do_status   = 1'b1;
                status_code = ST_EMPTY;
            end
            if (do_emit || do_status) begin
                n_len = '0;
            end
        end
    end

    // sequencer and output register next state
    always_comb begin
        n_state     = r_state;
        n_rd_addr   = r_rd_addr;
        n_last_addr = r_last_addr;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (do_status) begin
                    n_out.out_byte = 8'd0;
                    n_out.status   = status_code;
                    n_out.last     = 1'b1;
                    n_out_valid    = 1'b1;
                end else if (do_emit) begin
                    n_rd_addr   = AW'(r_trim_front);
                    n_last_addr = last_full[AW-1:0];
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (out_free) begin
                    n_out.out_byte = r_rd_data;
                    n_out.status   = ST_DATA;
                    n_out.last     = show_last;
                    n_out_valid    = 1'b1;
                    if (show_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rd_addr = r_rd_addr + AW'(1);
                        n_state   = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // frame memory: write on append, registered read while streaming
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_len[AW-1:0]] <= i_in.rx_byte;
        end
        if (r_state == S_READ) begin
            r_rd_data <= mem[r_rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_addr   <= n_rd_addr;
        r_last_addr <= n_last_addr;
        r_out       <= n_out;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_stop   <= 1'b1;
            r_stop_byte  <= 8'd13;
            r_drop_stop  <= 1'b1;
            r_trim_front <= 6'd0;
            r_trim_back  <= 6'd0;
            r_max_len    <= 6'd63;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_USE_STOP:  r_use_stop   <= i_cfg_data[0];
                CFG_STOP_BYTE: r_stop_byte  <= i_cfg_data;
                CFG_DROP_STOP: r_drop_stop  <= i_cfg_data[0];
                CFG_TRIM_FRNT: r_trim_front <= i_cfg_data[5:0];
                CFG_TRIM_BACK: r_trim_back  <= i_cfg_data[5:0];
                CFG_MAX_LEN:   r_max_len    <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ hdl/sbbd_checker.sv @@
module sbbd_sva (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input sbbd_pkg::t_out_item o_out
);
    import sbbd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // status results are single, zero-byte and last
    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ST_DATA) |-> o_out.last && (o_out.out_byte == 8'd0))
        else $error("malformed status result");

    // no input taken while a result is stuck
    a_no_in_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input ready while output stalled");

    // input stays blocked while a frame is still being sent
    a_frame_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_DATA) && !o_out.last |-> !o_in_ready)
        else $error("input ready before frame finished");

endmodule

bind stop_byte_barcode_deframer sbbd_sva u_sbbd_sva (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

@@ verif/sbbd_checker.sv @@
module sbbd_checker #(
    parameter int unsigned FRAME_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  sbbd_pkg::t_in_item             i_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  sbbd_pkg::t_out_item            i_out,
    input  logic                           i_cfg_wr_en,
    input  logic [sbbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    output int unsigned                    o_pending,
    output int unsigned                    o_fail_count
);
    import sbbd_pkg::*;

    localparam int unsigned AW = $clog2(FRAME_DEPTH);

    // register copies
    logic       use_stop;
    logic [7:0] stop_val;
    logic       drop_stop;
    logic [5:0] trim_lead;
    logic [5:0] trim_tail;
    logic [5:0] max_len;

    // frame being collected
    logic [7:0]  frame_mem [FRAME_DEPTH];
    int unsigned frame_len;

    // results still to arrive, oldest first
    t_out_item   expected_q [$];
    t_out_item   oldest;
    int unsigned fails = 0;

    // single status result, frame discarded
    function automatic void add_status(input logic [1:0] code);
        expected_q.push_back(t_out_item'{out_byte: 8'd0, status: code, last: 1'b1});
        frame_len = 0;
    endfunction

    // trimmed frame bytes, or one empty-frame status when nothing is left
    function automatic void emit_frame();
        int unsigned cut;
        int unsigned count;
        cut = int'(trim_lead) + int'(trim_tail);
        if (frame_len <= cut) begin
            add_status(ST_EMPTY);
        end else begin
            count = frame_len - cut;
            for (int unsigned k = 0; k < count; k++) begin
                expected_q.push_back(t_out_item'{
                    out_byte: frame_mem[AW'(int'(trim_lead) + k)],
                    status: ST_DATA, last: (k + 1 == count)});
            end
            frame_len = 0;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            use_stop  = 1'b1;
            stop_val  = 8'd13;
            drop_stop = 1'b1;
            trim_lead = 6'd0;
            trim_tail = 6'd0;
            max_len   = 6'd63;
            frame_len = 0;
            expected_q.delete();
        end else begin
            // result transfer against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result: out_byte %0h status %0d last %0d",
                           i_out.out_byte, i_out.status, i_out.last);
                    fails++;
                end else begin
                    oldest = expected_q.pop_front();
                    if (i_out.out_byte !== oldest.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", oldest.out_byte, i_out.out_byte);
                        fails++;
                    end
                    if (i_out.status !== oldest.status) begin
                        $error("status: expected %0d, got %0d", oldest.status, i_out.status);
                        fails++;
                    end
                    if (i_out.last !== oldest.last) begin
                        $error("last: expected %0d, got %0d", oldest.last, i_out.last);
                        fails++;
                    end
                end
            end

            // input transfer: update the frame and queue its results
            if (i_in_valid && i_in_ready) begin
                if (i_in.mode) begin
                    if (use_stop) begin
                        add_status(ST_TIMEOUT);
                    end else begin
                        emit_frame();
                    end
                end else if (use_stop && i_in.rx_byte == stop_val) begin
                    if (!drop_stop && frame_len >= FRAME_DEPTH) begin
                        add_status(ST_OVERFLOW);
                    end else begin
                        // kept stop byte skips the length limit
                        if (!drop_stop) begin
                            frame_mem[AW'(frame_len)] = i_in.rx_byte;
                            frame_len++;
                        end
                        emit_frame();
                    end
                end else if (frame_len >= FRAME_DEPTH) begin
                    add_status(ST_OVERFLOW);
                end else begin
                    frame_mem[AW'(frame_len)] = i_in.rx_byte;
                    frame_len++;
                    if (frame_len > int'(max_len)) begin
                        add_status(ST_OVERFLOW);
                    end
                end
            end

            // register writes
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_USE_STOP:  use_stop  = i_cfg_data[0];
                    CFG_STOP_BYTE: stop_val  = i_cfg_data;
                    CFG_DROP_STOP: drop_stop = i_cfg_data[0];
                    CFG_TRIM_FRNT: trim_lead = i_cfg_data[5:0];
                    CFG_TRIM_BACK: trim_tail = i_cfg_data[5:0];
                    CFG_MAX_LEN:   max_len   = i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fails;
    end

endmodule

@@ verif/testbench.sv @@
module testbench;
    import sbbd_pkg::*;

    localparam int unsigned DEPTH        = 64;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned RANDOM_ITEMS = 170;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in        = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out_item            o_out;

    int unsigned pending;
    int unsigned fail_count;
    int unsigned cycle_count = 0;
    int unsigned sent        = 0;
    bit          gaps_on     = 1'b1;

    // register values that shape the random frames
    logic       cur_stop_mode = 1'b1;
    logic [7:0] cur_stop      = 8'd13;
    logic [5:0] cur_max       = 6'd63;

    stop_byte_barcode_deframer #(.FRAME_DEPTH(DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sbbd_checker #(.FRAME_DEPTH(DEPTH)) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_ready <= !(gaps_on && $urandom_range(0, 99) < 29);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL stop_byte_barcode_deframer");
            $finish;
        end
    end

    // one input transfer, with random idle cycles in front
    task automatic send_item(input logic is_timeout, input logic [7:0] value);
        while (gaps_on && $urandom_range(0, 99) < 29) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{mode: is_timeout, rx_byte: value};
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    // hold input until every expected result has arrived
    task automatic drain(input int unsigned settle);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [7:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic write_config(input logic use_stop, input logic [7:0] stop,
                                input logic drop, input logic [5:0] lead,
                                input logic [5:0] tail, input logic [5:0] limit);
        write_reg(CFG_USE_STOP,  {7'd0, use_stop});
        write_reg(CFG_STOP_BYTE, stop);
        write_reg(CFG_DROP_STOP, {7'd0, drop});
        write_reg(CFG_TRIM_FRNT, {2'd0, lead});
        write_reg(CFG_TRIM_BACK, {2'd0, tail});
        write_reg(CFG_MAX_LEN,   {2'd0, limit});
        i_cfg_wr_en   <= 1'b0;
        cur_stop_mode = use_stop;
        cur_stop      = stop;
        cur_max       = limit;
    endtask

    // a frame of random content, mostly short, ended by stop byte or timeout
    task automatic send_frame();
        int unsigned len;
        int unsigned pick;
        logic [7:0]  value;
        pick = $urandom_range(0, 29);
        if (pick == 0) begin
            len = int'(cur_max) + 1 + $urandom_range(0, 2);
        end else if (pick == 1) begin
            len = int'(cur_max);
        end else begin
            len = $urandom_range(0, 8);
        end
        for (int unsigned k = 0; k < len; k++) begin
            value = 8'($urandom_range(0, 255));
            // mostly keep the frame going past a stray stop byte
            if (cur_stop_mode && value == cur_stop && $urandom_range(0, 9) != 0) begin
                value = ~value;
            end
            send_item(1'b0, value);
        end
        if (cur_stop_mode && $urandom_range(0, 9) != 0) begin
            send_item(1'b0, cur_stop);
        end else begin
            send_item(1'b1, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int unsigned item_goal;
        int unsigned phase;
        logic [7:0]  stop;
        logic [5:0]  lead;
        logic [5:0]  tail;
        logic [5:0]  limit;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: timeout before any byte, frame with extreme bytes, bare stop byte
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h0D);
        send_item(1'b0, 8'h0D);
        send_item(1'b0, 8'hAA);
        send_item(1'b1, 8'hFF);

        // timeout mode with nothing stored
        drain(6);
        write_config(1'b0, 8'h0D, 1'b1, 6'd0, 6'd0, 6'd63);
        send_item(1'b1, 8'h5A);

        // kept stop byte one past the limit, then an overflow
        drain(6);
        write_config(1'b1, 8'hFF, 1'b0, 6'd0, 6'd0, 6'd2);
        send_item(1'b0, 8'h01);
        send_item(1'b0, 8'h02);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h01);
        send_item(1'b0, 8'h02);
        send_item(1'b0, 8'h03);

        // timeout mode with trimming: nothing left, then a trimmed frame
        drain(6);
        write_config(1'b0, 8'h00, 1'b1, 6'd1, 6'd1, 6'd63);
        send_item(1'b0, 8'h11);
        send_item(1'b0, 8'h22);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h31);
        send_item(1'b0, 8'h42);
        send_item(1'b0, 8'h53);
        send_item(1'b0, 8'h64);
        send_item(1'b1, 8'h00);

        // zero length limit and widest trims
        drain(6);
        write_config(1'b1, 8'h0D, 1'b1, 6'd63, 6'd63, 6'd0);
        send_item(1'b0, 8'h7E);
        send_item(1'b0, 8'h0D);

        // random phases
        item_goal = sent + RANDOM_ITEMS;
        phase = 0;
        while (sent < item_goal) begin
            drain(6);
            case ($urandom_range(0, 3))
                0: stop = 8'h00;
                1: stop = 8'hFF;
                default: stop = 8'($urandom_range(0, 255));
            endcase
            lead = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 2));
            tail = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0, 1: limit = 6'd63;
                2: limit = 6'($urandom_range(1, 63));
                default: limit = 6'($urandom_range(2, 10));
            endcase
            write_config($urandom_range(0, 2) != 0, stop, 1'($urandom_range(0, 1)),
                         lead, tail, limit);
            // one phase with no idling on either side
            gaps_on <= (phase != 2);
            repeat ($urandom_range(3, 8)) begin
                send_frame();
                if ($urandom_range(0, 14) == 0) begin
                    drain(0);
                end
            end
            phase++;
        end

        drain(20);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS stop_byte_barcode_deframer");
        end else begin
            $display("FAIL stop_byte_barcode_deframer");
        end
        $finish;
    end

endmodule
